[sv/unaligned_access_beat_splitter_assert.svh]
// assertion helpers for the splitter control module
`ifndef UNALIGNED_ACCESS_BEAT_SPLITTER_ASSERT_SVH
`define UNALIGNED_ACCESS_BEAT_SPLITTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UABS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define UABS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/uabs_pkg.sv]
`timescale 1ns / 1ps
package uabs_pkg;

   localparam int ADDR_WIDTH_DEF     = 32;
   localparam int LANE_BYTES_MAX_DEF = 4;

   localparam logic [1:0] LANE_LOG2_RESET = 2'd2;

   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_RESP  = 2'd2;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_CPL   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BEAT,
      ST_RESP,
      ST_CPL
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] address;
      logic [3:0]  size;
      logic [63:0] write_value;
      logic [31:0] read_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] beat_address;
      logic [3:0]  byte_enable;
      logic [31:0] beat_data;
      logic [63:0] read_value;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [3:0] remaining;
      logic [1:0] offset;
   } beat_query_type;

   typedef struct packed {
      logic [3:0] enable;
      logic [2:0] count;
   } beat_info_type;

endpackage

[sv/uabs_beat_unit.sv]
`timescale 1ns / 1ps
module uabs_beat_unit import uabs_pkg::*; (
   input  logic [1:0]     lane_log2,
   input  beat_query_type query,
   output beat_info_type  info
);

   logic [3:0] size_en;
   logic [3:0] shifted;
   logic [3:0] lane_en;
   logic [3:0] enable;

   always_comb begin
      case (query.remaining)
         4'd0:    size_en = 4'h0;
         4'd1:    size_en = 4'h1;
         4'd2:    size_en = 4'h3;
         4'd3:    size_en = 4'h7;
         default: size_en = 4'hF;
      endcase
   end

   always_comb begin
      case (lane_log2)
         2'd0:    lane_en = 4'h1;
         2'd1:    lane_en = 4'h3;
         default: lane_en = 4'hF;
      endcase
   end

   assign shifted = size_en << query.offset;
   assign enable  = shifted & lane_en;

   assign info.enable = enable;
   assign info.count  = 3'(enable[0]) + 3'(enable[1]) + 3'(enable[2]) + 3'(enable[3]);

endmodule

[sv/uabs_ctrl.sv]
`timescale 1ns / 1ps
`include "unaligned_access_beat_splitter_assert.svh"
module uabs_ctrl import uabs_pkg::*; #(
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [1:0]     lane_log2,
   input  logic           start,
   input  req_type        req_item,
   output logic           busy,
   output beat_query_type query,
   input  beat_info_type  info,
   output logic           rsp_strobe,
   output rsp_type        rsp_item
);

   // beat addresses wrap at the narrower of the address space and the port
   localparam int AW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;

   state_type state_ff, state_in;

   logic [1:0]    func_ff, func_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [1:0]    off_ff, off_in;
   logic [3:0]    rem_ff, rem_in;
   logic [63:0]   value_ff, value_in;
   logic [31:0]   rdata_ff, rdata_in;
   logic          pending_ff, pending_in;
   logic [3:0]    left_ff, left_in;
   logic [3:0]    pos_ff, pos_in;
   logic [1:0]    first_off_ff, first_off_in;
   logic [63:0]   asm_ff, asm_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic [1:0]    lane_mask;
   logic [AW-1:0] lane_step;
   logic [AW-1:0] addr_m;
   logic [3:0]    size_c;
   logic [1:0]    req_off;
   logic [3:0]    beat_rem_next;
   logic [3:0]    resp_left_next;
   logic [31:0]   wdata;
   logic [31:0]   byte_mask;
   logic [31:0]   rd_masked;
   logic [31:0]   rd_aligned;
   logic [63:0]   placed;
   logic [1:0]    resp_off;

   always_comb begin
      case (lane_log2)
         2'd0:    lane_mask = 2'd0;
         2'd1:    lane_mask = 2'd1;
         default: lane_mask = 2'd3;
      endcase
   end

   assign lane_step = AW'(3'b001 << lane_log2);
   assign addr_m    = req_item.address[AW-1:0];
   assign size_c    = (req_item.size > 4'd8) ? 4'd8 : req_item.size;
   assign req_off   = addr_m[1:0] & lane_mask;
   assign resp_off  = first_off_ff & lane_mask;

   // the shared beat unit serves request beats and read responses
   assign query.remaining = (state_ff == ST_RESP) ? left_ff : rem_ff;
   assign query.offset    = (state_ff == ST_RESP) ? resp_off : off_ff;

   assign beat_rem_next  = rem_ff - {1'b0, info.count};
   assign resp_left_next = left_ff - {1'b0, info.count};

   always_comb begin
      case (off_ff)
         2'd0:    wdata = value_ff[31:0];
         2'd1:    wdata = {value_ff[23:0], 8'd0};
         2'd2:    wdata = {value_ff[15:0], 16'd0};
         default: wdata = {value_ff[7:0], 24'd0};
      endcase
   end

   assign byte_mask = {{8{info.enable[3]}}, {8{info.enable[2]}},
                       {8{info.enable[1]}}, {8{info.enable[0]}}};
   assign rd_masked = rdata_ff & byte_mask;

   always_comb begin
      case (resp_off)
         2'd0:    rd_aligned = rd_masked;
         2'd1:    rd_aligned = {8'd0, rd_masked[31:8]};
         2'd2:    rd_aligned = {16'd0, rd_masked[31:16]};
         default: rd_aligned = {24'd0, rd_masked[31:24]};
      endcase
   end

   assign placed = {32'd0, rd_aligned} << {pos_ff[2:0], 3'b000};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_item.func)
                  FUNC_READ, FUNC_WRITE: begin
                     if (size_c != 4'd0) begin
                        state_in = ST_BEAT;
                     end else if (req_item.func == FUNC_READ) begin
                        state_in = ST_CPL;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  FUNC_RESP: state_in = pending_ff ? ST_RESP : ST_IDLE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_BEAT: begin
            if (beat_rem_next == 4'd0) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         ST_CPL:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and result word
   always_comb begin
      func_in       = func_ff;
      cur_in        = cur_ff;
      off_in        = off_ff;
      rem_in        = rem_ff;
      value_in      = value_ff;
      rdata_in      = rdata_ff;
      pending_in    = pending_ff;
      left_in       = left_ff;
      pos_in        = pos_ff;
      first_off_in  = first_off_ff;
      asm_in        = asm_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_item.func)
                  FUNC_READ, FUNC_WRITE: begin
                     func_in      = req_item.func;
                     cur_in       = {addr_m[AW-1:2], addr_m[1:0] & ~lane_mask};
                     off_in       = req_off;
                     rem_in       = size_c;
                     value_in     = req_item.write_value;
                     pending_in   = (req_item.func == FUNC_READ) && (size_c != 4'd0);
                     left_in      = size_c;
                     pos_in       = 4'd0;
                     first_off_in = req_off;
                     asm_in       = '0;
                  end
                  FUNC_RESP: rdata_in = req_item.read_data;
                  default: ;
               endcase
            end
         end
         ST_BEAT: begin
            rsp_strobe_in       = 1'b1;
            rsp_in.kind         = (func_ff == FUNC_WRITE) ? KIND_WRITE : KIND_READ;
            rsp_in.beat_address = 32'(cur_ff);
            rsp_in.byte_enable  = info.enable;
            rsp_in.beat_data    = (func_ff == FUNC_WRITE) ? wdata : 32'd0;
            rsp_in.last         = (beat_rem_next == 4'd0);
            rem_in              = beat_rem_next;
            cur_in              = cur_ff + lane_step;
            off_in              = 2'd0;
            case (info.count)
               3'd0:    value_in = value_ff;
               3'd1:    value_in = {8'd0, value_ff[63:8]};
               3'd2:    value_in = {16'd0, value_ff[63:16]};
               3'd3:    value_in = {24'd0, value_ff[63:24]};
               default: value_in = {32'd0, value_ff[63:32]};
            endcase
         end
         ST_RESP: begin
            asm_in       = pos_ff[3] ? asm_ff : (asm_ff | placed);
            pos_in       = pos_ff + {1'b0, info.count};
            left_in      = resp_left_next;
            first_off_in = 2'd0;
            if (resp_left_next == 4'd0) begin
               pending_in        = 1'b0;
               rsp_strobe_in     = 1'b1;
               rsp_in.kind       = KIND_CPL;
               rsp_in.read_value = asm_in;
               rsp_in.last       = 1'b1;
            end
         end
         ST_CPL: begin
            rsp_strobe_in = 1'b1;
            rsp_in.kind   = KIND_CPL;
            rsp_in.last   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pending_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pending_ff    <= pending_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      cur_ff       <= cur_in;
      off_ff       <= off_in;
      rem_ff       <= rem_in;
      value_ff     <= value_in;
      rdata_ff     <= rdata_in;
      left_ff      <= left_in;
      pos_ff       <= pos_in;
      first_off_ff <= first_off_in;
      asm_ff       <= asm_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `UABS_ASSERT_NOW(a_beat_has_bytes, state_ff == ST_BEAT, rem_ff != 4'd0,
      "beat state entered with no bytes left")
   `UABS_ASSERT_NOW(a_resp_needs_pending, state_ff == ST_RESP, pending_ff,
      "response handled with no read pending")
   `UABS_ASSERT_NOW(a_beat_enable_nonzero,
      rsp_strobe_ff && (rsp_ff.kind != KIND_CPL), rsp_ff.byte_enable != 4'h0,
      "bus beat word with no byte enabled")
   `UABS_ASSERT_NOW(a_cpl_is_last, rsp_strobe_ff && (rsp_ff.kind == KIND_CPL),
      rsp_ff.last, "read completion not marked last")
   `UABS_ASSERT_NEXT(a_write_drops_pending,
      (state_ff == ST_IDLE) && start && (req_item.func == FUNC_WRITE), !pending_ff,
      "write request left a read pending")

endmodule

[sv/unaligned_access_beat_splitter.sv]
`timescale 1ns / 1ps
// channel   ports                                   handshake
// req       start, busy, req_item                   taken when start and not busy
// rsp       rsp_strobe, rsp_item                    one cycle per word, no stall
// csr       csr_write_enable, csr_write_data        lane width, written on enable
//
// a request of n beats holds busy while its beats are issued; beats leave one
// per cycle through the result register, set by the shared beat-enable unit
// a response to a pending read or a zero-size read holds busy for one cycle
// a zero-size write, a stray response or an unused code never raises busy
// reset clears the sequencer, the read-pending flag and sets 4-byte lanes
// the receiver cannot stall: every word is shown for exactly one cycle
module unaligned_access_beat_splitter import uabs_pkg::*; #(
   parameter int ADDR_WIDTH     = ADDR_WIDTH_DEF,
   parameter int LANE_BYTES_MAX = LANE_BYTES_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_item,
   output logic       rsp_strobe,
   output rsp_type    rsp_item,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);

   localparam logic [1:0] LANE_LOG2_CAP = (LANE_BYTES_MAX >= 4) ? 2'd2 :
                                          (LANE_BYTES_MAX >= 2) ? 2'd1 : 2'd0;

   logic [1:0]     lane_cfg_ff;
   logic [1:0]     lane_cfg_in;
   logic [1:0]     lane_sel;
   logic [1:0]     lane_log2;
   beat_query_type query;
   beat_info_type  info;

   assign lane_cfg_in = csr_write_enable ? csr_write_data : lane_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_cfg_ff <= LANE_LOG2_RESET;
      end else begin
         lane_cfg_ff <= lane_cfg_in;
      end
   end

   // code 3 means 4-byte lanes, then capped by the widest lane built
   assign lane_sel  = (lane_cfg_ff == 2'd3) ? 2'd2 : lane_cfg_ff;
   assign lane_log2 = (lane_sel > LANE_LOG2_CAP) ? LANE_LOG2_CAP : lane_sel;

   uabs_beat_unit u_beat (
      .lane_log2 (lane_log2),
      .query     (query),
      .info      (info)
   );

   uabs_ctrl #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .lane_log2  (lane_log2),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .query      (query),
      .info       (info),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
